### hw/rtl/u16u8_pkg.sv
`default_nettype none

package u16u8_pkg;

    localparam int QUEUE_DEPTH = 2;

    // surrogate classification of a code unit
    localparam logic [15:0] SurrMask  = 16'hFC00;
    localparam logic [15:0] HighSurr  = 16'hD800;
    localparam logic [15:0] LowSurr   = 16'hDC00;
    localparam logic [20:0] SuppBase  = 21'h10000;
    localparam logic [20:0] Lim1Byte  = 21'h00080;
    localparam logic [20:0] Lim2Byte  = 21'h00800;
    localparam logic [20:0] Lim3Byte  = 21'h10000;

    // apb register map
    localparam logic RegBigEndian = 1'b0;

    typedef struct packed {
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic       text_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] utf8_byte;
        logic       last_of_run;
        logic       error;
    } t_out_item;

    // one queued run: the bytes that one input item causes
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            err;
    } t_run;

endpackage

`default_nettype wire

### hw/rtl/u16u8_front.sv
`default_nettype none

module u16u8_front
    import u16u8_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_big_endian,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_item i_item,
    output logic          o_push,
    output t_run          o_run,
    input  wire logic     i_full
);

    logic [9:0]  r_held;
    logic        r_pending;
    logic        r_halted;
    logic [9:0]  n_held;
    logic        n_pending;
    logic        n_halted;

    logic [15:0] unit;
    logic        is_high;
    logic        is_low;
    logic        accept;
    logic [20:0] pair_cp;
    t_run        enc_unit;
    t_run        enc_pair;
    t_run        err_run;

    function automatic t_run encode(input logic [20:0] cp);
        t_run r;
        r.err   = 1'b0;
        r.bytes = '0;
        if (cp < Lim1Byte) begin
            r.bytes[0] = cp[7:0];
            r.last_idx = 2'd0;
        end else if (cp < Lim2Byte) begin
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
            r.last_idx = 2'd1;
        end else if (cp < Lim3Byte) begin
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
            r.last_idx = 2'd2;
        end else begin
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
            r.last_idx = 2'd3;
        end
        return r;
    endfunction

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    assign unit    = i_big_endian ? {i_item.first_byte, i_item.second_byte}
                                  : {i_item.second_byte, i_item.first_byte};
    assign is_high = (unit & SurrMask) == HighSurr;
    assign is_low  = (unit & SurrMask) == LowSurr;
    assign pair_cp = {1'b0, r_held, unit[9:0]} + SuppBase;

    assign enc_unit = encode({5'b0, unit});
    assign enc_pair = encode(pair_cp);

    always_comb begin
        err_run          = '0;
        err_run.err      = 1'b1;
        err_run.last_idx = 2'd0;
    end

    always_comb begin
        n_held    = r_held;
        n_pending = r_pending;
        n_halted  = r_halted;
        o_push    = 1'b0;
        o_run     = enc_unit;
        if (accept) begin
            if (r_halted) begin
                o_push = 1'b0;
            end else if (r_pending) begin
                n_pending = 1'b0;
                o_push    = 1'b1;
                if (is_low) begin
                    o_run = enc_pair;
                end else begin
                    o_run    = err_run;
                    n_halted = 1'b1;
                end
            end else if (is_high) begin
                if (i_item.text_end) begin
                    // an unpaired high surrogate at the end is only an error big-endian
                    o_push = i_big_endian;
                    o_run  = err_run;
                end else begin
                    n_held    = unit[9:0];
                    n_pending = 1'b1;
                end
            end else begin
                o_push = 1'b1;
                o_run  = enc_unit;
            end
            if (i_item.text_end) begin
                n_pending = 1'b0;
                n_halted  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held    <= '0;
            r_pending <= 1'b0;
            r_halted  <= 1'b0;
        end else begin
            r_held    <= n_held;
            r_pending <= n_pending;
            r_halted  <= n_halted;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/u16u8_queue.sv
`default_nettype none

module u16u8_queue
    import u16u8_pkg::*;
#(
    parameter int Depth = QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_run i_run,
    output logic      o_full,
    output logic      o_head_valid,
    output t_run      o_head,
    input  wire logic i_pop
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    t_run            r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full       = r_count == FullCnt;
    assign o_head_valid = r_count != '0;
    assign o_head       = r_mem[r_rd_ptr];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/u16u8_back.sv
`default_nettype none

module u16u8_back
    import u16u8_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_head_valid,
    input  wire t_run i_head,
    output logic      o_pop,
    output logic      o_valid,
    output t_out_item o_item,
    input  wire logic i_ready
);

    logic       r_valid;
    t_out_item  r_item;
    logic [1:0] r_idx;
    logic [1:0] n_idx;
    logic       load;
    logic       is_last;

    assign load    = i_head_valid && (!r_valid || i_ready);
    assign is_last = r_idx == i_head.last_idx;
    assign o_pop   = load && is_last;
    assign n_idx   = is_last ? 2'd0 : r_idx + 2'd1;

    assign o_valid = r_valid;
    assign o_item  = r_item;

    // one byte of the head run per cycle into the output register, while that register is empty or i_ready takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid            <= 1'b1;
                r_idx              <= n_idx;
                r_item.utf8_byte   <= i_head.bytes[r_idx];
                r_item.last_of_run <= is_last;
                r_item.error       <= i_head.err;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/utf16_to_utf8_transcoder_unit.sv
`default_nettype none

// channel   direction  handshake                  payload
// input     in         i_in_valid / o_in_ready    i_in_item  (t_in_item)
// output    out        o_out_valid / i_out_ready  o_out_item (t_out_item)
// config    in         psel / penable / pready    paddr, pwdata, prdata
//
// the back end sends one utf-8 byte per cycle, when the output takes it, from
// the head of the run queue, so a code point's byte count sets its cost
// the front end classifies a unit in the cycle it is accepted; a high surrogate
// held for its pair gives no byte, so such an item costs the back end nothing
// reset is synchronous; no clearing pass
// output stalls fill the run queue, then o_in_ready drops

module utf16_to_utf8_transcoder_unit
    import u16u8_pkg::*;
#(
    parameter int QueueDepth = QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_item    i_in_item,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_item        o_out_item,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic r_big_endian;
    logic push;
    t_run push_run;
    logic q_full;
    logic head_valid;
    t_run head_run;
    logic pop;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == RegBigEndian) ? {31'b0, r_big_endian} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_big_endian <= 1'b0;
        end else if (psel && penable && pwrite && pready && paddr[2] == RegBigEndian) begin
            r_big_endian <= pwdata[0];
        end
    end

    u16u8_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_big_endian (r_big_endian),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_item       (i_in_item),
        .o_push       (push),
        .o_run        (push_run),
        .i_full       (q_full)
    );

    u16u8_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_run        (push_run),
        .o_full       (q_full),
        .o_head_valid (head_valid),
        .o_head       (head_run),
        .i_pop        (pop)
    );

    u16u8_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head_run),
        .o_pop        (pop),
        .o_valid      (o_out_valid),
        .o_item       (o_out_item),
        .i_ready      (i_out_ready)
    );

endmodule

`default_nettype wire

### verif/tb_utf16_to_utf8_transcoder_unit.sv
`default_nettype none

module tb_utf16_to_utf8_transcoder_unit;
    import u16u8_pkg::*;

    localparam logic [2:0] AddrBigEndian = 3'(4 * RegBigEndian);
    localparam int IdleSettle = 8;
    localparam int EndSettle = 16;
    localparam int CycleLimit = 200000;
    localparam int MaxReports = 10;
    localparam int RandomItems = 176;

    localparam t_out_item PairError = '{utf8_byte: 8'h00, last_of_run: 1'b1, error: 1'b1};

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } t_rx_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_item = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_item;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // predictor state and its copy of the register
    logic       cfg_big_endian = 1'b0;
    logic [9:0] held_bits = '0;
    logic       high_held = 1'b0;
    logic       text_halted = 1'b0;

    t_out_item utf8_expected[$];
    int        n_fail = 0;
    int        items_sent = 0;
    int        burst_left = 0;
    int        cycle_count = 0;

    t_rx_mode   rx_mode = RX_ALWAYS;
    int         rx_left = 0;
    logic [7:0] rx_mask = 8'hFF;

    utf16_to_utf8_transcoder_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic void note_failure(string what);
        n_fail++;
        if (n_fail <= MaxReports) begin
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        end
    endfunction

    function automatic void push_code_point(logic [20:0] cp);
        logic [7:0] b[4];
        int n;
        if (cp < Lim1Byte) begin
            b[0] = cp[7:0];
            n = 1;
        end else if (cp < Lim2Byte) begin
            b[0] = {3'b110, cp[10:6]};
            b[1] = {2'b10, cp[5:0]};
            n = 2;
        end else if (cp < Lim3Byte) begin
            b[0] = {4'b1110, cp[15:12]};
            b[1] = {2'b10, cp[11:6]};
            b[2] = {2'b10, cp[5:0]};
            n = 3;
        end else begin
            b[0] = {5'b11110, cp[20:18]};
            b[1] = {2'b10, cp[17:12]};
            b[2] = {2'b10, cp[11:6]};
            b[3] = {2'b10, cp[5:0]};
            n = 4;
        end
        for (int k = 0; k < n; k++) begin
            utf8_expected.push_back('{utf8_byte: b[k], last_of_run: (k == n - 1), error: 1'b0});
        end
    endfunction

    function automatic void predict_utf8(t_in_item it);
        logic [15:0] code_unit;
        code_unit = cfg_big_endian ? {it.first_byte, it.second_byte}
                                   : {it.second_byte, it.first_byte};
        if (text_halted) begin
            // rest of the text is dropped
        end else if (high_held) begin
            high_held = 1'b0;
            if ((code_unit & SurrMask) == LowSurr) begin
                push_code_point({1'b0, held_bits, code_unit[9:0]} + SuppBase);
            end else begin
                text_halted = 1'b1;
                utf8_expected.push_back(PairError);
            end
        end else if ((code_unit & SurrMask) == HighSurr) begin
            if (it.text_end) begin
                if (cfg_big_endian) begin
                    utf8_expected.push_back(PairError);
                end
            end else begin
                held_bits = code_unit[9:0];
                high_held = 1'b1;
            end
        end else begin
            push_code_point({5'b0, code_unit});
        end
        if (it.text_end) begin
            high_held = 1'b0;
            text_halted = 1'b0;
        end
    endfunction

    // input first, so the prediction for an accepted item is queued before any byte is checked
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                predict_utf8(i_in_item);
            end
            if (o_out_valid && i_out_ready) begin
                if (utf8_expected.size() == 0) begin
                    note_failure($sformatf("unexpected byte %h last %b err %b",
                        o_out_item.utf8_byte, o_out_item.last_of_run, o_out_item.error));
                end else begin
                    want = utf8_expected.pop_front();
                    if (o_out_item.utf8_byte !== want.utf8_byte
                            || o_out_item.last_of_run !== want.last_of_run
                            || o_out_item.error !== want.error) begin
                        note_failure($sformatf(
                            "exp byte %h last %b err %b, got byte %h last %b err %b",
                            want.utf8_byte, want.last_of_run, want.error,
                            o_out_item.utf8_byte, o_out_item.last_of_run,
                            o_out_item.error));
                    end
                end
            end
        end
    end

    // receiver stall pattern, reshuffled when its random run length runs out
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 96);
            rx_mask = 8'($urandom_range(1, 255));
        end
        rx_left--;
        case (rx_mode)
            RX_ALWAYS: i_out_ready <= 1'b1;
            RX_COIN: i_out_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: i_out_ready <= ($urandom_range(0, 3) == 0);
            default: i_out_ready <= rx_mask[rx_left[2:0]];
        endcase
    end

    task automatic send_unit(logic [15:0] code_unit, logic fin);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 5);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        if (cfg_big_endian) begin
            i_in_item <= '{first_byte: code_unit[15:8], second_byte: code_unit[7:0],
                           text_end: fin};
        end else begin
            i_in_item <= '{first_byte: code_unit[7:0], second_byte: code_unit[15:8],
                           text_end: fin};
        end
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        @(negedge i_clk);
    endtask

    // a held high surrogate gives no byte, so keep waiting past the last expected byte
    task automatic wait_for_idle();
        i_in_valid <= 1'b0;
        while (utf8_expected.size() != 0) @(negedge i_clk);
        repeat (IdleSettle) @(negedge i_clk);
    endtask

    task automatic write_big_endian(logic value);
        wait_for_idle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= AddrBigEndian;
        pwdata <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        cfg_big_endian = value;
        @(negedge i_clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== 32'(value)) begin
            note_failure($sformatf("big_endian reads %h, written %b", prdata, value));
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_single_units();
        write_big_endian(1'b0);
        send_unit(16'h0000, 1'b0);
        send_unit(16'h007F, 1'b0);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07FF, 1'b0);
        send_unit(16'h0800, 1'b0);
        send_unit(16'hFFFF, 1'b0);
        // lone low surrogates go out as plain three-byte units
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDFFF, 1'b1);
    endtask

    task automatic test_surrogate_pairs();
        send_unit(16'hD800, 1'b0);
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hDFFF, 1'b1);
    endtask

    task automatic test_broken_pairs();
        send_unit(16'hD800, 1'b0);
        send_unit(16'h0041, 1'b0);
        send_unit(16'h0042, 1'b0);
        send_unit(16'h0043, 1'b1);
        // high followed by high, ending the text on the second one
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hD800, 1'b1);
    endtask

    task automatic test_high_at_end();
        send_unit(16'hD812, 1'b1);
        write_big_endian(1'b1);
        send_unit(16'hD812, 1'b1);
        send_unit(16'h00E9, 1'b1);
    endtask

    task automatic test_endian_switch();
        send_unit(16'hD83D, 1'b0);
        write_big_endian(1'b0);
        send_unit(16'hDE00, 1'b1);
    endtask

    task automatic send_random_text();
        int n_units;
        int pick;
        logic fin;
        logic [15:0] cu;
        n_units = $urandom_range(1, 8);
        for (int i = 0; i < n_units; i++) begin
            fin = (i == n_units - 1);
            pick = $urandom_range(0, 99);
            if (pick < 18) begin
                send_unit(16'($urandom_range(16'h0000, 16'h007F)), fin);
            end else if (pick < 34) begin
                send_unit(16'($urandom_range(16'h0080, 16'h07FF)), fin);
            end else if (pick < 54) begin
                cu = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(16'h0800, 16'hD7FF))
                                                 : 16'($urandom_range(16'hE000, 16'hFFFF));
                send_unit(cu, fin);
            end else if (pick < 78) begin
                send_unit(16'($urandom_range(16'hD800, 16'hDBFF)), 1'b0);
                send_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), fin);
            end else if (pick < 84) begin
                send_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), fin);
            end else if (pick < 90) begin
                send_unit(16'($urandom_range(16'hD800, 16'hDBFF)), 1'b0);
                cu = 16'($urandom);
                if ((cu & SurrMask) == LowSurr) begin
                    cu[10] = 1'b0;
                end
                send_unit(cu, fin);
            end else if (pick < 94) begin
                send_unit(16'($urandom_range(16'hD800, 16'hDBFF)), 1'b1);
                break;
            end else begin
                send_unit(16'($urandom), fin);
            end
        end
    endtask

    task automatic test_random_traffic();
        int quota;
        for (int phase = 0; phase < 4; phase++) begin
            write_big_endian(phase[0]);
            quota = items_sent + RandomItems / 4;
            while (items_sent < quota) begin
                send_random_text();
                if ($urandom_range(0, 9) == 0) begin
                    wait_for_idle();
                end
            end
        end
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_single_units();
        test_surrogate_pairs();
        test_broken_pairs();
        test_high_at_end();
        test_endian_switch();
        test_random_traffic();
        wait_for_idle();
        repeat (EndSettle) @(posedge i_clk);
        if (n_fail == 0 && utf8_expected.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
hw/rtl/u16u8_pkg.sv
hw/rtl/u16u8_front.sv
hw/rtl/u16u8_queue.sv
hw/rtl/u16u8_back.sv
hw/rtl/utf16_to_utf8_transcoder_unit.sv
verif/tb_utf16_to_utf8_transcoder_unit.sv
